// ----- rtl/stsr_pkg.sv -----
`timescale 1ns / 1ps
// Package for the sphere terminator span rasterizer: widths, register indexes,
// controller states and the command, status and tag types. Depends on nothing.

package stsr_pkg;

  localparam int COORD_W    = 11;
  localparam int SUN_W      = 16;
  localparam int RAD_W      = 10;
  localparam int SQ_IN_W    = 2 * RAD_W;
  localparam int SQ_ROOT_W  = RAD_W;
  localparam int SQ_REM_W   = SQ_ROOT_W + 2;
  localparam int SQ_STAGES  = SQ_ROOT_W;
  localparam int PROD_W     = SUN_W + COORD_W;
  localparam int DOT_W      = PROD_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SUN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUN_RIGHT   = 3'd0,
    REG_SUN_UP      = 3'd1,
    REG_SUN_TOWARD  = 3'd2,
    REG_DISC_RADIUS = 3'd3,
    REG_CLIP_TOP    = 3'd4,
    REG_CLIP_BOTTOM = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQUARE,
    ST_HW_ISSUE,
    ST_HW_WAIT,
    ST_STREAM,
    ST_DRAIN
  } ctrl_state_t;

  typedef struct packed {
    logic load_row;
    logic hw_issue;
    logic hw_latch;
    logic px_issue;
    logic px_last;
  } dp_cmd_t;

  typedef struct packed {
    logic row_ok;
    logic hw_ready;
    logic hw_zero;
    logic dx_at_end;
    logic row_done;
  } dp_status_t;

  typedef struct packed {
    logic               is_hw;
    logic               last;
    logic [COORD_W-1:0] dx;
  } sq_tag_t;

endpackage

// ----- rtl/stsr_isqrt_pipe.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, with a tag carried alongside.
// Depends on stsr_pkg.

module stsr_isqrt_pipe
  import stsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [SQ_IN_W-1:0]   in_value,
  input  sq_tag_t              in_tag,
  output logic                 out_valid,
  output logic [SQ_ROOT_W-1:0] out_root,
  output sq_tag_t              out_tag
);

  logic [SQ_STAGES-1:0] v_r;
  logic [SQ_REM_W-1:0]  rem_r  [SQ_STAGES];
  logic [SQ_ROOT_W-1:0] root_r [SQ_STAGES];
  logic [SQ_IN_W-1:0]   rad_r  [SQ_STAGES];
  sq_tag_t              tag_r  [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    logic                 v_in;
    logic [SQ_REM_W-1:0]  rem_in;
    logic [SQ_ROOT_W-1:0] root_in;
    logic [SQ_IN_W-1:0]   rad_in;
    sq_tag_t              tag_in;
    logic [SQ_REM_W-1:0]  rem_sh;
    logic [SQ_REM_W-1:0]  trial;
    logic                 ge;

    if (g == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_value;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign v_in    = v_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign rad_in  = rad_r[g-1];
      assign tag_in  = tag_r[g-1];
    end

    always_comb begin
      rem_sh = {rem_in[SQ_REM_W-3:0], rad_in[SQ_IN_W-1 -: 2]};
      trial  = {root_in, 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else begin
        v_r[g] <= v_in;
      end
      rem_r[g]  <= ge ? (rem_sh - trial) : rem_sh;
      root_r[g] <= {root_in[SQ_ROOT_W-2:0], ge};
      rad_r[g]  <= {rad_in[SQ_IN_W-3:0], 2'b00};
      tag_r[g]  <= tag_in;
    end
  end

  assign out_valid = v_r[SQ_STAGES-1];
  assign out_root  = root_r[SQ_STAGES-1];
  assign out_tag   = tag_r[SQ_STAGES-1];

endmodule

// ----- rtl/stsr_ctrl.sv -----
`timescale 1ns / 1ps
// Controller for the span rasterizer: sequences row check, half width and pixel walk.
// Depends on stsr_pkg.

module stsr_ctrl
  import stsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = status.row_ok ? ST_SQUARE : ST_IDLE;
      end
      ST_SQUARE: begin
        state_nxt = ST_HW_ISSUE;
      end
      ST_HW_ISSUE: begin
        state_nxt = ST_HW_WAIT;
      end
      ST_HW_WAIT: begin
        if (status.hw_ready) state_nxt = status.hw_zero ? ST_IDLE : ST_STREAM;
      end
      ST_STREAM: begin
        if (status.dx_at_end) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status.row_done) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cmd.load_row = start;
      end
      ST_HW_ISSUE: begin
        cmd.hw_issue = 1'b1;
      end
      ST_HW_WAIT: begin
        cmd.hw_latch = status.hw_ready;
      end
      ST_STREAM: begin
        cmd.px_issue = 1'b1;
        cmd.px_last  = status.dx_at_end;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/stsr_datapath.sv -----
`timescale 1ns / 1ps
// Datapath for the span rasterizer: configuration registers, pixel pipeline, run tracker
// and result register. Depends on stsr_pkg and stsr_isqrt_pipe.

module stsr_datapath
  import stsr_pkg::*;
#(
  parameter int MAX_RADIUS        = 1023,
  parameter int MAX_SPANS_PER_ROW = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_write_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [COORD_W-1:0] in_row_offset,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_span_start,
  output logic signed [COORD_W-1:0] out_span_row,
  output logic [COORD_W-1:0]        out_span_length,
  output logic                      out_span_lit,
  output logic                      out_run_overflow,
  output logic                      out_last_span
);

  localparam int CNT_W = $clog2(MAX_SPANS_PER_ROW);
  localparam int LIM_W = 15;

  logic signed [SUN_W-1:0]   sun_right_r;
  logic signed [SUN_W-1:0]   sun_up_r;
  logic signed [SUN_W-1:0]   sun_toward_r;
  logic [RAD_W-1:0]          radius_r;
  logic signed [COORD_W-1:0] clip_top_r;
  logic signed [COORD_W-1:0] clip_bottom_r;

  logic signed [COORD_W-1:0] dy_r;
  logic [RAD_W-1:0]          r_eff;
  logic signed [COORD_W:0]   dy_x;
  logic signed [COORD_W:0]   top_x;
  logic signed [COORD_W:0]   bot_x;
  logic signed [COORD_W:0]   r_pos;
  logic signed [COORD_W:0]   r_neg;
  logic [SQ_IN_W-1:0]        rr_r;
  logic signed [2*COORD_W-1:0] dy_sq_full;
  logic [SQ_IN_W-1:0]        dysq_r;
  logic [SQ_IN_W-1:0]        w_row_r;
  logic signed [PROD_W-1:0]  bdy_r;

  logic [SQ_ROOT_W-1:0]      hw_r;
  logic signed [COORD_W-1:0] dx_r;

  logic                      s1_v_r;
  logic                      s1_last_r;
  logic [COORD_W-1:0]        s1_dx_r;
  logic [SQ_IN_W-1:0]        s1_sq_r;
  logic signed [2*COORD_W-1:0] dx_sq_full;
  logic                      s2_v_r;
  logic                      s2_last_r;
  logic [COORD_W-1:0]        s2_dx_r;
  logic [SQ_IN_W-1:0]        s2_w_r;

  logic                      sq_in_v;
  logic [SQ_IN_W-1:0]        sq_in_value;
  sq_tag_t                   sq_in_tag;
  logic                      sq_out_v;
  logic [SQ_ROOT_W-1:0]      sq_out_root;
  sq_tag_t                   sq_out_tag;

  logic                      m_v_r;
  logic                      m_last_r;
  logic [COORD_W-1:0]        m_dx_r;
  logic signed [PROD_W-1:0]  m_pa_r;
  logic signed [PROD_W-1:0]  m_pc_r;
  logic signed [DOT_W-1:0]   dot;

  logic                      px_v_r;
  logic                      px_last_r;
  logic signed [COORD_W-1:0] px_dx_r;
  logic                      px_lit_r;

  logic                      active_r;
  logic                      ovf_r;
  logic                      fin_r;
  logic [CNT_W-1:0]          n_r;
  logic signed [COORD_W-1:0] run_start_r;
  logic                      run_lit_r;
  logic                      change;
  logic                      emit_mid;
  logic signed [COORD_W:0]   mid_len;
  logic [COORD_W:0]          fin_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sun_right_r   <= '0;
      sun_up_r      <= '0;
      sun_toward_r  <= '0;
      radius_r      <= '0;
      clip_top_r    <= {1'b1, {(COORD_W-1){1'b0}}};
      clip_bottom_r <= {1'b0, {(COORD_W-1){1'b1}}};
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_SUN_RIGHT:   sun_right_r   <= cfg_data;
        REG_SUN_UP:      sun_up_r      <= cfg_data;
        REG_SUN_TOWARD:  sun_toward_r  <= cfg_data;
        REG_DISC_RADIUS: radius_r      <= cfg_data[RAD_W-1:0];
        REG_CLIP_TOP:    clip_top_r    <= cfg_data[COORD_W-1:0];
        REG_CLIP_BOTTOM: clip_bottom_r <= cfg_data[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Row setup: clip test, squares and the row's remaining radius squared.
  always_comb begin
    if ({{(LIM_W-RAD_W){1'b0}}, radius_r} > LIM_W'(MAX_RADIUS)) begin
      r_eff = RAD_W'(MAX_RADIUS);
    end else begin
      r_eff = radius_r;
    end
    dy_x       = {dy_r[COORD_W-1], dy_r};
    top_x      = {clip_top_r[COORD_W-1], clip_top_r};
    bot_x      = {clip_bottom_r[COORD_W-1], clip_bottom_r};
    r_pos      = {2'b00, r_eff};
    r_neg      = -r_pos;
    dy_sq_full = dy_r * dy_r;
    dx_sq_full = dx_r * dx_r;
  end

  assign status.row_ok    = (r_eff != '0) && (dy_x >= top_x) && (dy_x >= r_neg) &&
                            (dy_x <= bot_x) && (dy_x <= r_pos);
  assign status.hw_ready  = sq_out_v && sq_out_tag.is_hw;
  assign status.hw_zero   = (sq_out_root == '0);
  assign status.dx_at_end = (dx_r == {1'b0, hw_r});
  assign status.row_done  = fin_r;

  always_ff @(posedge clk) begin
    if (cmd.load_row) dy_r <= in_row_offset;
    rr_r    <= r_eff * r_eff;
    dysq_r  <= dy_sq_full[SQ_IN_W-1:0];
    w_row_r <= rr_r - dysq_r;
    bdy_r   <= sun_up_r * dy_r;
    if (cmd.hw_latch) begin
      hw_r <= sq_out_root;
      dx_r <= -$signed({1'b0, sq_out_root});
    end else if (cmd.px_issue) begin
      dx_r <= dx_r + 1'b1;
    end
  end

  // Pixel pipeline: dx squared, remaining depth, square root, dot products, sign.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      m_v_r  <= 1'b0;
      px_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.px_issue;
      s2_v_r <= s1_v_r;
      m_v_r  <= sq_out_v && !sq_out_tag.is_hw;
      px_v_r <= m_v_r;
    end
    s1_last_r <= cmd.px_last;
    s1_dx_r   <= dx_r;
    s1_sq_r   <= dx_sq_full[SQ_IN_W-1:0];
    s2_last_r <= s1_last_r;
    s2_dx_r   <= s1_dx_r;
    s2_w_r    <= w_row_r - s1_sq_r;
    m_last_r  <= sq_out_tag.last;
    m_dx_r    <= sq_out_tag.dx;
    m_pa_r    <= sun_right_r * $signed(sq_out_tag.dx);
    m_pc_r    <= sun_toward_r * $signed({1'b0, sq_out_root});
    px_last_r <= m_last_r;
    px_dx_r   <= m_dx_r;
    px_lit_r  <= !dot[DOT_W-1] && (dot != '0);
  end

  assign dot = DOT_W'(m_pa_r) - DOT_W'(bdy_r) + DOT_W'(m_pc_r);

  always_comb begin
    sq_in_v           = cmd.hw_issue || s2_v_r;
    sq_in_value       = cmd.hw_issue ? w_row_r : s2_w_r;
    sq_in_tag.is_hw   = cmd.hw_issue;
    sq_in_tag.last    = s2_last_r;
    sq_in_tag.dx      = s2_dx_r;
  end

  stsr_isqrt_pipe u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_in_v),
    .in_value  (sq_in_value),
    .in_tag    (sq_in_tag),
    .out_valid (sq_out_v),
    .out_root  (sq_out_root),
    .out_tag   (sq_out_tag)
  );

  // Run tracker. The final span passes through fin_r, so it leaves in the cycle after any span
  // closed by the last pixel and never collides with it.
  always_comb begin
    change   = px_v_r && active_r && !ovf_r && (px_lit_r != run_lit_r);
    emit_mid = change && (n_r != CNT_W'(MAX_SPANS_PER_ROW - 1));
    mid_len  = {px_dx_r[COORD_W-1], px_dx_r} - {run_start_r[COORD_W-1], run_start_r};
    fin_len  = {1'b0, {(COORD_W-SQ_ROOT_W){1'b0}}, hw_r} + 1'b1
               - {run_start_r[COORD_W-1], run_start_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_row) begin
      active_r <= 1'b0;
      ovf_r    <= 1'b0;
      fin_r    <= 1'b0;
      n_r      <= '0;
    end else begin
      fin_r <= px_v_r && px_last_r;
      if (px_v_r && !active_r) begin
        active_r <= 1'b1;
      end
      if (change && !emit_mid) begin
        ovf_r <= 1'b1;
      end
      if (emit_mid) begin
        n_r <= n_r + 1'b1;
      end
    end
    if ((px_v_r && !active_r) || emit_mid) begin
      run_start_r <= px_dx_r;
      run_lit_r   <= px_lit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit_mid || fin_r;
    end
    out_span_start   <= run_start_r;
    out_span_row     <= dy_r;
    out_span_lit     <= run_lit_r;
    out_run_overflow <= fin_r && ovf_r;
    out_last_span    <= fin_r;
    out_span_length  <= fin_r ? fin_len[COORD_W-1:0] : mid_len[COORD_W-1:0];
  end

endmodule

// ----- rtl/sphere_terminator_span_rasterizer.sv -----
`timescale 1ns / 1ps
// Sphere terminator span rasterizer: one row offset in, lit and dark spans out.
// A row of half width h walks 2*h+1 pixels at one per cycle through a ten stage
// square root pipeline; a clipped row or a row of zero half width gives no span.
// busy stays high until the last span of the row is on the result ports.
// Reset is synchronous and active low; the receiver cannot stall results.

module sphere_terminator_span_rasterizer
  import stsr_pkg::*;
#(
  parameter int MAX_RADIUS        = 1023,
  parameter int MAX_SPANS_PER_ROW = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_row_offset,
  input  logic                      cfg_write_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_span_start,
  output logic signed [COORD_W-1:0] out_span_row,
  output logic [COORD_W-1:0]        out_span_length,
  output logic                      out_span_lit,
  output logic                      out_run_overflow,
  output logic                      out_last_span
);

  dp_cmd_t    cmd;
  dp_status_t status;

  stsr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  stsr_datapath #(
    .MAX_RADIUS        (MAX_RADIUS),
    .MAX_SPANS_PER_ROW (MAX_SPANS_PER_ROW)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_row_offset    (in_row_offset),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_span_start   (out_span_start),
    .out_span_row     (out_span_row),
    .out_span_length  (out_span_length),
    .out_span_lit     (out_span_lit),
    .out_run_overflow (out_run_overflow),
    .out_last_span    (out_last_span)
  );

endmodule

// ----- rtl/stsr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the span rasterizer, bound to the top level.
// Depends on stsr_pkg and sphere_terminator_span_rasterizer.

module stsr_checker
  import stsr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [COORD_W-1:0] out_span_length,
  input logic               out_run_overflow,
  input logic               out_last_span
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted item");

  a_mid_span_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_span |-> busy && !out_run_overflow)
    else $error("inner span seen outside a row or with overflow set");

  a_last_span_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_span |-> !busy)
    else $error("final span seen while the row is still busy");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_span |=> !out_valid)
    else $error("span directly after the final span of a row");

  a_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_span_length != '0)
    else $error("span of zero length");

endmodule

bind sphere_terminator_span_rasterizer stsr_checker u_stsr_checker (.*);
